// ===== hw/rtl/u8ucc_pkg.sv =====
// Shared types and constants for the UTF-8 unique codepoint collector.
// Used by the lookup engine and the top level; depends on nothing.

package u8ucc_pkg;

	localparam int CP_W    = 21;
	localparam int BYTE_W  = 8;
	localparam int HOLD_N  = 3;

	// Whitespace codepoints that are skipped
	localparam logic [CP_W-1:0] CP_SPACE = 21'h00020;
	localparam logic [CP_W-1:0] CP_TAB   = 21'h00009;
	localparam logic [CP_W-1:0] CP_LF    = 21'h0000A;
	localparam logic [CP_W-1:0] CP_CR    = 21'h0000D;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_ADDED   = 3'd0,
		KIND_PRESENT = 3'd1,
		KIND_SPACE   = 3'd2,
		KIND_FULL    = 3'd3,
		KIND_END     = 3'd4
	} kind_t;

	// Decoder sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FLUSH,
		ST_FRESH,
		ST_SEARCH,
		ST_OUTPUT
	} dec_state_t;

	// Lookup engine states
	typedef enum logic {
		LK_IDLE,
		LK_SCAN
	} lk_state_t;

	// Request from the decoder to the lookup engine
	typedef struct packed {
		logic            start;
		logic [CP_W-1:0] cp;
	} lk_req_t;

	// Answer from the lookup engine, one-cycle done pulse
	typedef struct packed {
		logic        done;
		kind_t       kind;
		logic [7:0]  slot;
	} lk_resp_t;

endpackage

// ===== hw/rtl/utf8_unique_codepoint_collector.sv =====
// Top level: lenient UTF-8 decoder feeding the unique codepoint lookup engine.
// Depends on u8ucc_pkg and u8ucc_lookup.

// Takes one byte per input transfer (new_text in s_tuser) and returns 0 to 4 results per
// byte, the last one flagged by m_tlast. Whitespace, a full table and an empty table are
// answered without a scan; otherwise the table RAM is scanned one entry per cycle through
// its single read port until the codepoint is found, or it is appended after a miss on the
// last live entry. A bad continuation emits up to three held bytes, each as its own lookup,
// before the byte itself is taken afresh. The table is not cleared: a fill count marks which
// entries are live, so no clearing pass follows reset or new_text. Results sit in an output
// register, so the next byte is taken while a result waits for m_tready.

module utf8_unique_codepoint_collector #(
	parameter int TABLE_ENTRIES = 192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tuser,   // [0] new_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [20:0] codepoint, [28:21] slot, [36:29] entry_count, zeros
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast    // last_result
);

	localparam int CPW = u8ucc_pkg::CP_W;

	u8ucc_pkg::dec_state_t state_q, state_d;
	logic [7:0]     byte_q, byte_d;
	logic [CPW-1:0] partial_q, partial_d;
	logic [1:0]     exp_q, exp_d;
	logic [1:0]     held_n_q, held_n_d;
	logic [7:0]     hold_q [u8ucc_pkg::HOLD_N];
	logic [7:0]     hold_d [u8ucc_pkg::HOLD_N];
	logic           ended_q, ended_d;
	logic           flushing_q, flushing_d;
	logic [1:0]     flush_idx_q, flush_idx_d;
	logic [CPW-1:0] cur_cp_q, cur_cp_d;
	logic           cur_last_q, cur_last_d;
	u8ucc_pkg::kind_t res_kind_q, res_kind_d;
	logic [7:0]     res_slot_q, res_slot_d;

	logic           m_tvalid_q, m_tvalid_d;
	logic [CPW-1:0] m_cp_q, m_cp_d;
	u8ucc_pkg::kind_t m_kind_q, m_kind_d;
	logic [7:0]     m_slot_q, m_slot_d;
	logic [7:0]     m_count_q, m_count_d;
	logic           m_last_q, m_last_d;

	u8ucc_pkg::lk_req_t  lk_req;
	u8ucc_pkg::lk_resp_t lk_resp;
	logic [7:0]          lk_count;
	logic                lk_clear;
	logic                accept, cont, lead;

	assign s_tready = (state_q == u8ucc_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign lk_clear = accept && s_tuser;
	assign cont     = (byte_q[7:6] == 2'b10);
	assign lead     = (byte_q >= 8'hC0) && (byte_q <= 8'hF7);

	u8ucc_lookup #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_lookup (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (lk_clear),
		.req    (lk_req),
		.resp   (lk_resp),
		.count  (lk_count)
	);

	// Sequence decode, flush of held bytes, lookup and result transfer
	always_comb begin
		state_d     = state_q;
		byte_d      = byte_q;
		partial_d   = partial_q;
		exp_d       = exp_q;
		held_n_d    = held_n_q;
		hold_d      = hold_q;
		ended_d     = ended_q;
		flushing_d  = flushing_q;
		flush_idx_d = flush_idx_q;
		cur_cp_d    = cur_cp_q;
		cur_last_d  = cur_last_q;
		res_kind_d  = res_kind_q;
		res_slot_d  = res_slot_q;
		m_tvalid_d  = m_tvalid_q && !m_tready;
		m_cp_d      = m_cp_q;
		m_kind_d    = m_kind_q;
		m_slot_d    = m_slot_q;
		m_count_d   = m_count_q;
		m_last_d    = m_last_q;
		lk_req.start = 1'b0;
		lk_req.cp    = cur_cp_q;
		case (state_q)
			u8ucc_pkg::ST_IDLE: begin
				if (accept) begin
					byte_d = s_tdata;
					if (s_tuser) begin
						partial_d = '0;
						exp_d     = '0;
						held_n_d  = '0;
						ended_d   = 1'b0;
					end
					state_d = u8ucc_pkg::ST_DECODE;
				end
			end
			u8ucc_pkg::ST_DECODE: begin
				if (ended_q) begin
					state_d = u8ucc_pkg::ST_IDLE;
				end else if (exp_q != 2'd0) begin
					if (cont) begin
						// extend the open sequence
						partial_d = {partial_q[CPW-7:0], byte_q[5:0]};
						exp_d     = exp_q - 2'd1;
						if (exp_q == 2'd1) begin
							held_n_d     = '0;
							cur_cp_d     = {partial_q[CPW-7:0], byte_q[5:0]};
							cur_last_d   = 1'b1;
							flushing_d   = 1'b0;
							lk_req.start = 1'b1;
							lk_req.cp    = {partial_q[CPW-7:0], byte_q[5:0]};
							state_d      = u8ucc_pkg::ST_SEARCH;
						end else begin
							if (held_n_q < 2'd3) begin
								hold_d[held_n_q] = byte_q;
								held_n_d         = held_n_q + 2'd1;
							end
							state_d = u8ucc_pkg::ST_IDLE;
						end
					end else begin
						// bad continuation: close the sequence, emit held bytes raw
						exp_d       = '0;
						partial_d   = '0;
						flushing_d  = 1'b1;
						flush_idx_d = '0;
						state_d     = u8ucc_pkg::ST_FLUSH;
					end
				end else begin
					state_d = u8ucc_pkg::ST_FRESH;
				end
			end
			u8ucc_pkg::ST_FLUSH: begin
				if (flush_idx_q == held_n_q) begin
					held_n_d   = '0;
					flushing_d = 1'b0;
					state_d    = u8ucc_pkg::ST_FRESH;
				end else begin
					cur_cp_d     = CPW'(hold_q[flush_idx_q]);
					cur_last_d   = (2'(flush_idx_q + 2'd1) == held_n_q) && lead;
					lk_req.start = 1'b1;
					lk_req.cp    = CPW'(hold_q[flush_idx_q]);
					flush_idx_d  = flush_idx_q + 2'd1;
					state_d      = u8ucc_pkg::ST_SEARCH;
				end
			end
			u8ucc_pkg::ST_FRESH: begin
				if (byte_q == 8'h00) begin
					ended_d    = 1'b1;
					cur_cp_d   = '0;
					cur_last_d = 1'b1;
					res_kind_d = u8ucc_pkg::KIND_END;
					res_slot_d = '0;
					state_d    = u8ucc_pkg::ST_OUTPUT;
				end else if (lead) begin
					// open a new sequence and hold the lead byte
					if (byte_q[7:5] == 3'b110) begin
						partial_d = CPW'(byte_q & 8'h1F);
						exp_d     = 2'd1;
					end else if (byte_q[7:4] == 4'b1110) begin
						partial_d = CPW'(byte_q & 8'h0F);
						exp_d     = 2'd2;
					end else begin
						partial_d = CPW'(byte_q & 8'h07);
						exp_d     = 2'd3;
					end
					hold_d[0] = byte_q;
					held_n_d  = 2'd1;
					state_d   = u8ucc_pkg::ST_IDLE;
				end else begin
					// plain ASCII, stray continuation or invalid lead: take as is
					cur_cp_d     = CPW'(byte_q);
					cur_last_d   = 1'b1;
					lk_req.start = 1'b1;
					lk_req.cp    = CPW'(byte_q);
					state_d      = u8ucc_pkg::ST_SEARCH;
				end
			end
			u8ucc_pkg::ST_SEARCH: begin
				if (lk_resp.done) begin
					res_kind_d = lk_resp.kind;
					res_slot_d = lk_resp.slot;
					state_d    = u8ucc_pkg::ST_OUTPUT;
				end
			end
			u8ucc_pkg::ST_OUTPUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tvalid_d = 1'b1;
					m_cp_d     = cur_cp_q;
					m_kind_d   = res_kind_q;
					m_slot_d   = res_slot_q;
					m_count_d  = lk_count;
					m_last_d   = cur_last_q;
					state_d    = flushing_q ? u8ucc_pkg::ST_FLUSH : u8ucc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = u8ucc_pkg::ST_IDLE;
			end
		endcase
	end

	// Hold control and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= u8ucc_pkg::ST_IDLE;
			partial_q   <= '0;
			exp_q       <= '0;
			held_n_q    <= '0;
			ended_q     <= 1'b0;
			flushing_q  <= 1'b0;
			flush_idx_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			partial_q   <= partial_d;
			exp_q       <= exp_d;
			held_n_q    <= held_n_d;
			ended_q     <= ended_d;
			flushing_q  <= flushing_d;
			flush_idx_q <= flush_idx_d;
			m_tvalid_q  <= m_tvalid_d;
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		byte_q     <= byte_d;
		hold_q     <= hold_d;
		cur_cp_q   <= cur_cp_d;
		cur_last_q <= cur_last_d;
		res_kind_q <= res_kind_d;
		res_slot_q <= res_slot_d;
		m_cp_q     <= m_cp_d;
		m_kind_q   <= m_kind_d;
		m_slot_q   <= m_slot_d;
		m_count_q  <= m_count_d;
		m_last_q   <= m_last_d;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_count_q, m_slot_q, m_cp_q};
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

	a_open_has_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == u8ucc_pkg::ST_IDLE && exp_q != 2'd0) |-> (held_n_q != 2'd0))
		else $error("open sequence without a held lead byte");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		lk_resp.done |-> (state_q == u8ucc_pkg::ST_SEARCH))
		else $error("lookup answer outside search");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
		(m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
		else $error("result changed while waiting for transfer");

endmodule

// ===== hw/rtl/u8ucc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.

module u8ucc_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 192
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/u8ucc_lookup.sv =====
// Lookup engine: scans the unique codepoint table held in a RAM, adds new entries.
// Depends on u8ucc_pkg and u8ucc_ram.

module u8ucc_lookup #(
	parameter int TABLE_ENTRIES = 192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	input  u8ucc_pkg::lk_req_t req,
	output u8ucc_pkg::lk_resp_t resp,
	output logic [7:0]         count
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	u8ucc_pkg::lk_state_t state_q, state_d;
	logic [CW-1:0]              count_q, count_d;
	logic [IW-1:0]              cmp_q, cmp_d;
	logic [u8ucc_pkg::CP_W-1:0] cp_q, cp_d;
	u8ucc_pkg::lk_resp_t        resp_d;

	logic                       we, re;
	logic [IW-1:0]              waddr, raddr;
	logic [u8ucc_pkg::CP_W-1:0] wdata, rdata;
	logic                       full, space;

	assign full  = (count_q >= CW'(TABLE_ENTRIES));
	assign space = (req.cp == u8ucc_pkg::CP_SPACE) || (req.cp == u8ucc_pkg::CP_TAB) ||
	               (req.cp == u8ucc_pkg::CP_LF) || (req.cp == u8ucc_pkg::CP_CR);
	assign count = 8'(count_q);

	u8ucc_ram #(
		.WIDTH (u8ucc_pkg::CP_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Classify, then scan one entry per cycle; append on a miss
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		cmp_d       = cmp_q;
		cp_d        = cp_q;
		we          = 1'b0;
		waddr       = count_q[IW-1:0];
		wdata       = cp_q;
		re          = 1'b0;
		raddr       = '0;
		resp_d.done = 1'b0;
		resp_d.kind = u8ucc_pkg::KIND_ADDED;
		resp_d.slot = '0;
		case (state_q)
			u8ucc_pkg::LK_IDLE: begin
				if (clear) begin
					count_d = '0;
				end else if (req.start) begin
					if (full) begin
						resp_d.done = 1'b1;
						resp_d.kind = u8ucc_pkg::KIND_FULL;
					end else if (space) begin
						resp_d.done = 1'b1;
						resp_d.kind = u8ucc_pkg::KIND_SPACE;
					end else if (count_q == '0) begin
						we          = 1'b1;
						waddr       = '0;
						wdata       = req.cp;
						count_d     = CW'(1);
						resp_d.done = 1'b1;
						resp_d.kind = u8ucc_pkg::KIND_ADDED;
					end else begin
						re      = 1'b1;
						raddr   = '0;
						cmp_d   = '0;
						cp_d    = req.cp;
						state_d = u8ucc_pkg::LK_SCAN;
					end
				end
			end
			u8ucc_pkg::LK_SCAN: begin
				if (rdata == cp_q) begin
					resp_d.done = 1'b1;
					resp_d.kind = u8ucc_pkg::KIND_PRESENT;
					resp_d.slot = 8'(cmp_q);
					state_d     = u8ucc_pkg::LK_IDLE;
				end else if (CW'(cmp_q) + CW'(1) == count_q) begin
					we          = 1'b1;
					count_d     = count_q + CW'(1);
					resp_d.done = 1'b1;
					resp_d.kind = u8ucc_pkg::KIND_ADDED;
					resp_d.slot = 8'(count_q);
					state_d     = u8ucc_pkg::LK_IDLE;
				end else begin
					re    = 1'b1;
					raddr = IW'(cmp_q + 1'b1);
					cmp_d = IW'(cmp_q + 1'b1);
				end
			end
			default: begin
				state_d = u8ucc_pkg::LK_IDLE;
			end
		endcase
	end

	// Hold control state and register the answer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u8ucc_pkg::LK_IDLE;
			count_q <= '0;
			resp    <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			resp    <= resp_d;
		end
	end

	// Hold scan payload
	always_ff @(posedge clk) begin
		cmp_q <= cmp_d;
		cp_q  <= cp_d;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("table count beyond capacity");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (state_q == u8ucc_pkg::LK_IDLE))
		else $error("lookup started while a scan is running");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (count_q < CW'(TABLE_ENTRIES)))
		else $error("table write while full");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for utf8_unique_codepoint_collector.
// Drives text bytes on the slave stream and checks every result against an in-bench
// decoder and unique-codepoint table model; depends on u8ucc_pkg and the top level.

module tb;

	localparam int TABLE_N        = 192;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 1000;
	localparam int HOLD_CYCLES    = 400;

	// Directed text: two texts, the second opened by new_text
	localparam int DIR_N = 30;
	localparam logic [7:0] DIR_BYTES [DIR_N] = '{
		8'h41, 8'h41, 8'h20, 8'h09, 8'h0A, 8'h0D,
		8'hC3, 8'hA9,
		8'hE2, 8'h82, 8'hAC,
		8'hF7, 8'hBF, 8'hBF, 8'hBF,
		8'hF8, 8'hFF, 8'h80, 8'hBF,
		8'hE2, 8'h82, 8'h41,
		8'hC0, 8'h80,
		8'hF0, 8'h9F, 8'h98, 8'h00,
		8'h42, 8'h7F
	};

	typedef struct {
		logic [u8ucc_pkg::CP_W-1:0] cp;
		u8ucc_pkg::kind_t           kind;
		logic [7:0]                 slot;
		logic [7:0]                 count;
		logic                       last;
	} cp_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	// Model state of the decoder and the unique table
	logic [u8ucc_pkg::CP_W-1:0] asm_code;
	int                         cont_left;
	int                         held_n;
	logic [7:0]                 held_bytes [u8ucc_pkg::HOLD_N];
	logic [u8ucc_pkg::CP_W-1:0] seen_cps [TABLE_N];
	int                         seen_n;
	bit                         text_done;

	cp_result_t step_results [$];
	cp_result_t results_due [$];
	cp_result_t got;

	int  mismatches = 0;
	int  bytes_decoded = 0;
	int  src_idle_pct = 0;
	int  snk_idle_pct = 0;
	int  hold_token = 0;
	int  hold_seen = 0;
	int  hold_left = 0;
	int  quiet_cycles = 0;
	bit  fresh = 1'b0;

	utf8_unique_codepoint_collector #(
		.TABLE_ENTRIES(TABLE_N)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Classify one decoded codepoint against the unique table
	function automatic void classify_codepoint(logic [u8ucc_pkg::CP_W-1:0] cp);
		cp_result_t r;
		int hit;
		hit = -1;
		r.cp = cp;
		r.slot = 8'd0;
		r.last = 1'b0;
		if (seen_n >= TABLE_N) begin
			r.kind = u8ucc_pkg::KIND_FULL;
		end else if (cp == u8ucc_pkg::CP_SPACE || cp == u8ucc_pkg::CP_TAB ||
		             cp == u8ucc_pkg::CP_LF || cp == u8ucc_pkg::CP_CR) begin
			r.kind = u8ucc_pkg::KIND_SPACE;
		end else begin
			for (int i = 0; i < seen_n; i++)
				if (hit < 0 && seen_cps[i] == cp)
					hit = i;
			if (hit >= 0) begin
				r.kind = u8ucc_pkg::KIND_PRESENT;
				r.slot = 8'(hit);
			end else begin
				seen_cps[seen_n] = cp;
				r.kind = u8ucc_pkg::KIND_ADDED;
				r.slot = 8'(seen_n);
				seen_n++;
			end
		end
		r.count = 8'(seen_n);
		step_results.push_back(r);
	endfunction

	function automatic void open_seq(logic [7:0] b, logic [u8ucc_pkg::CP_W-1:0] bits,
	                                 int more);
		asm_code = bits;
		cont_left = more;
		held_bytes[0] = b;
		held_n = 1;
	endfunction

	// Work out the results one accepted byte causes and queue them
	function automatic void decode_byte(logic [7:0] b, logic nt);
		cp_result_t r;
		bit done;
		done = 1'b0;
		step_results.delete();
		if (nt) begin
			seen_n = 0;
			asm_code = '0;
			cont_left = 0;
			held_n = 0;
			text_done = 1'b0;
		end
		if (text_done)
			return;
		bytes_decoded++;
		if (cont_left != 0) begin
			if (b[7:6] == 2'b10) begin
				asm_code = {asm_code[u8ucc_pkg::CP_W-7:0], b[5:0]};
				cont_left--;
				if (cont_left == 0) begin
					held_n = 0;
					classify_codepoint(asm_code);
				end else if (held_n < u8ucc_pkg::HOLD_N) begin
					held_bytes[held_n] = b;
					held_n++;
				end
				done = 1'b1;
			end else begin
				// Flush the broken sequence as raw codepoints, then take the byte afresh
				for (int i = 0; i < held_n; i++)
					classify_codepoint({13'd0, held_bytes[i]});
				held_n = 0;
				cont_left = 0;
				asm_code = '0;
			end
		end
		if (!done) begin
			if (b == 8'h00) begin
				text_done = 1'b1;
				r.cp = '0;
				r.kind = u8ucc_pkg::KIND_END;
				r.slot = 8'd0;
				r.count = 8'(seen_n);
				r.last = 1'b0;
				step_results.push_back(r);
			end else if (b[7] == 1'b0) begin
				classify_codepoint({13'd0, b});
			end else if (b[7:5] == 3'b110) begin
				open_seq(b, {16'd0, b[4:0]}, 1);
			end else if (b[7:4] == 4'b1110) begin
				open_seq(b, {17'd0, b[3:0]}, 2);
			end else if (b[7:3] == 5'b11110) begin
				open_seq(b, {18'd0, b[2:0]}, 3);
			end else begin
				classify_codepoint({13'd0, b});
			end
		end
		if (step_results.size() > 0)
			step_results[step_results.size()-1].last = 1'b1;
		foreach (step_results[i])
			results_due.push_back(step_results[i]);
	endfunction

	// Offer one byte and wait for its transfer; called at a rising edge
	task automatic put_byte(input logic [7:0] b, input logic nt);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= nt;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		decode_byte(b, nt);
	endtask

	task automatic put_text_byte(input logic [7:0] b);
		put_byte(b, fresh);
		fresh = 1'b0;
	endtask

	function automatic logic [7:0] lead_byte(int n);
		logic [7:0] v;
		v = 8'($urandom_range(255));
		case (n)
			2: v[7:5] = 3'b110;
			3: v[7:4] = 4'b1110;
			default: v[7:3] = 5'b11110;
		endcase
		return v;
	endfunction

	// Send one character: mostly well-formed, some broken sequences and noise
	task automatic put_char();
		int sel;
		int n;
		sel = $urandom_range(99);
		n = $urandom_range(2, 4);
		if (sel < 35) begin
			put_text_byte(8'($urandom_range(8'h21, 8'h2F)));
		end else if (sel < 45) begin
			case ($urandom_range(3))
				0: put_text_byte(u8ucc_pkg::CP_SPACE[7:0]);
				1: put_text_byte(u8ucc_pkg::CP_TAB[7:0]);
				2: put_text_byte(u8ucc_pkg::CP_LF[7:0]);
				default: put_text_byte(u8ucc_pkg::CP_CR[7:0]);
			endcase
		end else if (sel < 55) begin
			put_text_byte(8'($urandom_range(1, 127)));
		end else if (sel < 85) begin
			put_text_byte(lead_byte(n));
			repeat (n - 1)
				put_text_byte({2'b10, 6'($urandom_range(63))});
		end else if (sel < 92) begin
			put_text_byte(lead_byte(n));
			repeat ($urandom_range(0, n - 2))
				put_text_byte({2'b10, 6'($urandom_range(63))});
		end else begin
			put_text_byte(8'($urandom_range(1, 255)));
		end
	endtask

	// Extremes of the byte, every result kind but full and every recovery path
	task automatic test_directed();
		src_idle_pct = 12;
		snk_idle_pct = 72;
		for (int i = 0; i < DIR_N; i++)
			put_byte(DIR_BYTES[i], (i == 0 || i == DIR_N - 1));
	endtask

	// Short random texts under one idling setting
	task automatic test_random_texts(input int src_pct, input int snk_pct, input int n_bytes);
		int target;
		target = bytes_decoded + n_bytes;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		while (bytes_decoded < target) begin
			fresh = 1'b1;
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(99) < 3)
					fresh = 1'b1;
				put_char();
			end
			if ($urandom_range(99) < 85) begin
				put_text_byte(8'h00);
				// Bytes after the end of the text are ignored
				if ($urandom_range(99) < 20)
					repeat ($urandom_range(1, 2))
						put_text_byte(8'($urandom_range(1, 255)));
			end
		end
	endtask

	// Fill the table with single-byte codepoints while the receiver holds off, then
	// check that everything after is reported as full and the end is still reported
	task automatic test_table_full();
		logic [7:0] b;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_token++;
		fresh = 1'b1;
		b = 8'h01;
		while (seen_n < TABLE_N) begin
			if (b != u8ucc_pkg::CP_SPACE[7:0] && b != u8ucc_pkg::CP_TAB[7:0] &&
			    b != u8ucc_pkg::CP_LF[7:0] && b != u8ucc_pkg::CP_CR[7:0] &&
			    !(b >= 8'hC0 && b <= 8'hF7))
				put_text_byte(b);
			if (seen_n == 100) begin
				put_text_byte(u8ucc_pkg::CP_SPACE[7:0]);
				put_text_byte(8'h01);
			end
			b++;
		end
		put_text_byte(8'h41);
		put_text_byte(u8ucc_pkg::CP_SPACE[7:0]);
		put_text_byte(8'hC3);
		put_text_byte(8'hA9);
		put_text_byte(8'hF0);
		put_text_byte(8'h9F);
		put_text_byte(8'h98);
		put_text_byte(8'h41);
		put_text_byte(8'h00);
	endtask

	// Drive m_tready: long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned seen);
		if (want != seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			mismatches++;
		end
	endfunction

	// Compare each result transfer with the oldest prediction; sampled mid-cycle
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				$error("result with none due: codepoint %0h kind %0d", m_tdata[20:0], m_tuser);
				mismatches++;
			end else begin
				got = results_due.pop_front();
				check_field("codepoint", got.cp, m_tdata[20:0]);
				check_field("kind", got.kind, m_tuser);
				check_field("slot", got.slot, m_tdata[28:21]);
				check_field("entry_count", got.count, m_tdata[36:29]);
				check_field("last_result", got.last, m_tlast);
			end
		end
	end

	// Stop a hung run: count cycles with no transfer on either side
	always @(negedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		asm_code = '0;
		cont_left = 0;
		held_n = 0;
		seen_n = 0;
		text_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_texts(12, 72, 20);
		test_random_texts(72, 12, 20);
		test_table_full();
		test_random_texts(0, 0, 20);
		s_tvalid <= 1'b0;
		// Drain, then give a stray late result time to show up
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
